FILE: sv/sv39pti_pkg.sv
// sv39pti_pkg: shared widths, codes, control word type and microcode rom
// for the sv39 page table insert block; no dependencies
package sv39pti_pkg;

  localparam int PoolPagesDef = 16;
  localparam int PpnW     = 44;
  localparam int PteW     = 54;
  localparam int IdxW     = 9;
  localparam int PteShift = 10;
  localparam int VpnW     = 27;
  localparam int ProtW    = 8;
  localparam int RootW    = 4;
  localparam int StatusW  = 2;
  localparam int AllocW   = 2;
  localparam int CfgIdxW  = 1;

  localparam logic [StatusW-1:0] ST_MAPPED    = 2'd0;
  localparam logic [StatusW-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [StatusW-1:0] ST_OUTSIDE   = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_POOL_BASE  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_FREE = 1'd1;

  typedef logic [2:0] step_t;
  localparam step_t STEP_CLEAR  = 3'd0;
  localparam step_t STEP_WAIT   = 3'd1;
  localparam step_t STEP_CHECK  = 3'd2;
  localparam step_t STEP_READ   = 3'd3;
  localparam step_t STEP_EVAL   = 3'd4;
  localparam step_t STEP_LEAF   = 3'd5;
  localparam step_t STEP_FINISH = 3'd6;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_CLR_BUSY = 3'd1,
    COND_NO_REQ   = 3'd2,
    COND_ROOT_BAD = 3'd3,
    COND_MORE     = 3'd4,
    COND_OUT_BUSY = 3'd5
  } cond_t;

  typedef struct packed {
    logic  clear;
    logic  accept;
    logic  check_root;
    logic  rd;
    logic  eval;
    logic  wr_leaf;
    logic  finish;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  typedef struct packed {
    logic we;
    logic re;
  } store_ctl_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '0;
    case (s)
      STEP_CLEAR: begin
        w.clear = 1'b1; w.cond = COND_CLR_BUSY; w.tgt_t = STEP_CLEAR; w.tgt_f = STEP_WAIT;
      end
      STEP_WAIT: begin
        w.accept = 1'b1; w.cond = COND_NO_REQ; w.tgt_t = STEP_WAIT; w.tgt_f = STEP_CHECK;
      end
      STEP_CHECK: begin
        w.check_root = 1'b1; w.cond = COND_ROOT_BAD; w.tgt_t = STEP_FINISH;
        w.tgt_f = STEP_READ;
      end
      STEP_READ: begin
        w.rd = 1'b1; w.cond = COND_ALWAYS; w.tgt_t = STEP_EVAL; w.tgt_f = STEP_EVAL;
      end
      STEP_EVAL: begin
        w.eval = 1'b1; w.cond = COND_MORE; w.tgt_t = STEP_READ; w.tgt_f = STEP_LEAF;
      end
      STEP_LEAF: begin
        w.wr_leaf = 1'b1; w.cond = COND_ALWAYS; w.tgt_t = STEP_FINISH; w.tgt_f = STEP_FINISH;
      end
      STEP_FINISH: begin
        w.finish = 1'b1; w.cond = COND_OUT_BUSY; w.tgt_t = STEP_FINISH; w.tgt_f = STEP_WAIT;
      end
      default: begin
        w.cond = COND_ALWAYS; w.tgt_t = STEP_WAIT; w.tgt_f = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/sv39pti_store.sv
// sv39pti_store: single-port table page store with registered read data
// depends on sv39pti_pkg
module sv39pti_store #(
  parameter int Depth = sv39pti_pkg::PoolPagesDef * (1 << sv39pti_pkg::IdxW),
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                         clk,
  input  sv39pti_pkg::store_ctl_t      ctl,
  input  logic [AddrW-1:0]             addr,
  input  logic [sv39pti_pkg::PteW-1:0] wdata,
  output logic [sv39pti_pkg::PteW-1:0] rdata
);

  logic [sv39pti_pkg::PteW-1:0] mem [0:Depth-1];
  logic [sv39pti_pkg::PteW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/sv39_page_table_insert.sv
// sv39_page_table_insert: microcoded sv39 page table insert over an on-chip page pool
// depends on sv39pti_pkg and sv39pti_store
//
//   channel | direction | handshake           | payload
//   in_     | request   | in_valid/in_ready   | root_page, virt_page, phys_page, prot_flags
//   out_    | result    | out_valid/out_ready | status, pages_allocated, leaf_entry
//   cfg_    | write     | cfg_wr_en           | cfg_index, cfg_wdata
//
// a full two-level walk steps through the root check, two read/evaluate pairs,
// the leaf write and the output load, all on the single store port
// a request rejected at the root goes from the root check straight to the output load;
// one failing at the root or middle level still passes the leaf step, which writes nothing
// after reset a clearing pass zeroes all POOL_PAGES*512 entries (8192 by default) of the store
// the next request is taken while a result waits in the output register
module sv39_page_table_insert #(
  parameter int POOL_PAGES = sv39pti_pkg::PoolPagesDef
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sv39pti_pkg::RootW-1:0]       in_root_page,
  input  logic [sv39pti_pkg::VpnW-1:0]        in_virt_page,
  input  logic [sv39pti_pkg::PpnW-1:0]        in_phys_page,
  input  logic [sv39pti_pkg::ProtW-1:0]       in_prot_flags,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sv39pti_pkg::StatusW-1:0]     out_status,
  output logic [sv39pti_pkg::AllocW-1:0]      out_pages_allocated,
  output logic [sv39pti_pkg::PteW-1:0]        out_leaf_entry,
  input  logic                                cfg_wr_en,
  input  logic [sv39pti_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [sv39pti_pkg::PpnW-1:0]        cfg_wdata
);

  localparam int PageW = $clog2(POOL_PAGES);
  localparam int IdxW  = sv39pti_pkg::IdxW;
  localparam int AddrW = PageW + IdxW;
  localparam int Depth = POOL_PAGES * (1 << IdxW);
  localparam int CntW  = $clog2(POOL_PAGES + 1);
  localparam int CandW = ((CntW > sv39pti_pkg::RootW) ? CntW : sv39pti_pkg::RootW) + 1;
  localparam int PpnW  = sv39pti_pkg::PpnW;
  localparam int PteW  = sv39pti_pkg::PteW;
  localparam int Shift = sv39pti_pkg::PteShift;

  sv39pti_pkg::step_t       pc_r, pc_nxt;
  sv39pti_pkg::uword_t      uw;
  sv39pti_pkg::store_ctl_t  st_ctl;

  logic [AddrW-1:0]                  clr_addr_r;
  logic [PpnW-1:0]                   base_r;
  logic [sv39pti_pkg::RootW-1:0]     first_free_r;
  logic [CntW-1:0]                   alloc_cnt_r;
  logic [sv39pti_pkg::RootW-1:0]     root_r;
  logic [sv39pti_pkg::VpnW-1:0]      vpn_r;
  logic [PpnW-1:0]                   phys_r;
  logic [sv39pti_pkg::ProtW-1:0]     prot_r;
  logic                              level_r;
  logic [PageW-1:0]                  page_r;
  logic [sv39pti_pkg::StatusW-1:0]   status_r;
  logic [sv39pti_pkg::AllocW-1:0]    pages_r;
  logic [PteW-1:0]                   leaf_r;
  logic                              out_valid_r;
  logic [sv39pti_pkg::StatusW-1:0]   out_status_r;
  logic [sv39pti_pkg::AllocW-1:0]    out_pages_r;
  logic [PteW-1:0]                   out_leaf_r;

  logic                  accept;
  logic [IdxW-1:0]       idx;
  logic [AddrW-1:0]      mem_addr;
  logic [PteW-1:0]       mem_wdata;
  logic [PteW-1:0]       rd_data;
  logic [CandW-1:0]      cand;
  logic                  cand_ok;
  logic                  entry_zero;
  logic [PpnW-1:0]       rel;
  logic                  rel_ok;
  logic                  root_bad;
  logic                  eval_fail;
  logic [PteW-1:0]       ptr_entry;
  logic [PteW-1:0]       leaf_val;
  logic                  cond_hit;
  logic                  out_load;
  logic                  leaf_ok;

  assign uw       = sv39pti_pkg::ucode(pc_r);
  assign in_ready = uw.accept;
  assign accept   = uw.accept & in_valid;

  assign idx = level_r ? vpn_r[2*IdxW-1:IdxW] : vpn_r[3*IdxW-1:2*IdxW];

  // allocation and pointer checks
  assign cand       = CandW'(first_free_r) + CandW'(alloc_cnt_r);
  assign cand_ok    = cand < CandW'(POOL_PAGES);
  assign entry_zero = (rd_data == '0);
  assign rel        = rd_data[PteW-1:Shift] - base_r;
  assign rel_ok     = rel < PpnW'(POOL_PAGES);
  assign root_bad   = CandW'(root_r) >= CandW'(POOL_PAGES);
  assign eval_fail  = entry_zero ? !cand_ok : !rel_ok;
  assign leaf_ok    = (status_r == sv39pti_pkg::ST_MAPPED);

  assign ptr_entry = {base_r + PpnW'(cand), (Shift - 1)'(0), 1'b1};
  assign leaf_val  = {phys_r, Shift'(0)} | PteW'(prot_r) | PteW'(1);

  always_comb begin
    if (uw.clear) begin
      mem_addr  = clr_addr_r;
      mem_wdata = '0;
    end else if (uw.wr_leaf) begin
      mem_addr  = {page_r, vpn_r[IdxW-1:0]};
      mem_wdata = leaf_val;
    end else begin
      mem_addr  = {page_r, idx};
      mem_wdata = ptr_entry;
    end
    st_ctl.we = uw.clear | (uw.eval & entry_zero & cand_ok) | (uw.wr_leaf & leaf_ok);
    st_ctl.re = uw.rd;
  end

  sv39pti_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk   (clk),
    .ctl   (st_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rd_data)
  );

  // step sequencing
  always_comb begin
    case (uw.cond)
      sv39pti_pkg::COND_ALWAYS:   cond_hit = 1'b1;
      sv39pti_pkg::COND_CLR_BUSY: cond_hit = (clr_addr_r != AddrW'(Depth - 1));
      sv39pti_pkg::COND_NO_REQ:   cond_hit = !in_valid;
      sv39pti_pkg::COND_ROOT_BAD: cond_hit = root_bad;
      sv39pti_pkg::COND_MORE:     cond_hit = !eval_fail & !level_r;
      sv39pti_pkg::COND_OUT_BUSY: cond_hit = out_valid_r & !out_ready;
      default:                    cond_hit = 1'b1;
    endcase
    pc_nxt = cond_hit ? uw.tgt_t : uw.tgt_f;
  end

  assign out_load = uw.finish & !(out_valid_r & !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= sv39pti_pkg::STEP_CLEAR;
      clr_addr_r   <= '0;
      base_r       <= '0;
      first_free_r <= sv39pti_pkg::RootW'(1);
      alloc_cnt_r  <= '0;
      level_r      <= 1'b0;
      status_r     <= sv39pti_pkg::ST_MAPPED;
      pages_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (uw.clear) begin
        clr_addr_r <= clr_addr_r + AddrW'(1);
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          sv39pti_pkg::CFG_POOL_BASE:  base_r       <= cfg_wdata;
          sv39pti_pkg::CFG_FIRST_FREE: first_free_r <= cfg_wdata[sv39pti_pkg::RootW-1:0];
          default: ;
        endcase
      end
      if (uw.check_root) begin
        level_r  <= 1'b0;
        pages_r  <= '0;
        status_r <= root_bad ? sv39pti_pkg::ST_OUTSIDE : sv39pti_pkg::ST_MAPPED;
      end
      if (uw.eval) begin
        level_r <= 1'b1;
        if (eval_fail) begin
          status_r <= entry_zero ? sv39pti_pkg::ST_EXHAUSTED : sv39pti_pkg::ST_OUTSIDE;
        end else if (entry_zero) begin
          alloc_cnt_r <= alloc_cnt_r + CntW'(1);
          pages_r     <= pages_r + sv39pti_pkg::AllocW'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      root_r <= in_root_page;
      vpn_r  <= in_virt_page;
      phys_r <= in_phys_page;
      prot_r <= in_prot_flags;
    end
    if (uw.check_root) begin
      page_r <= PageW'(root_r);
      leaf_r <= '0;
    end
    if (uw.eval && !eval_fail) begin
      page_r <= entry_zero ? cand[PageW-1:0] : rel[PageW-1:0];
    end
    if (uw.wr_leaf && leaf_ok) begin
      leaf_r <= leaf_val;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_pages_r  <= pages_r;
      out_leaf_r   <= leaf_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_pages_allocated = out_pages_r;
  assign out_leaf_entry      = out_leaf_r;

endmodule

FILE: sv/sv39pti_checker.sv
// sv39pti_checker: port-level assertions on the result channel, bound to the top level
// depends on sv39pti_pkg and sv39_page_table_insert
module sv39pti_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sv39pti_pkg::StatusW-1:0] out_status,
  input logic [sv39pti_pkg::AllocW-1:0]  out_pages_allocated,
  input logic [sv39pti_pkg::PteW-1:0]    out_leaf_entry
);

  // only three status codes exist
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == sv39pti_pkg::ST_MAPPED ||
                   out_status == sv39pti_pkg::ST_EXHAUSTED ||
                   out_status == sv39pti_pkg::ST_OUTSIDE))
    else $error("bad status code");

  // a failed insert reports no leaf entry
  a_fail_no_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != sv39pti_pkg::ST_MAPPED) |-> (out_leaf_entry == '0))
    else $error("leaf entry on failed insert");

  // a mapped leaf always carries the valid bit
  a_leaf_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sv39pti_pkg::ST_MAPPED) |-> out_leaf_entry[0])
    else $error("mapped leaf without valid bit");

  // at most two table pages per insert
  a_pages_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pages_allocated != sv39pti_pkg::AllocW'(3)))
    else $error("too many pages allocated");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_leaf_entry) &&
                                   $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind sv39_page_table_insert sv39pti_checker u_sv39pti_checker (.*);

FILE: dv/tb.sv
// tb: self-checking bench for sv39_page_table_insert; a scoreboard class keeps its own
// copy of the table pool and predicts every mapping result
// depends on sv39pti_pkg and the rtl of the block
module tb;
  import sv39pti_pkg::*;

  localparam int DrainCycles   = 16;
  localparam int WatchdogLimit = 3 * PoolPagesDef * (1 << IdxW);
  localparam logic [IdxW-1:0] HotIdx [4] = '{9'h000, 9'h1ff, 9'h0a5, 9'h15a};

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AllocW-1:0]  pages;
    logic [PteW-1:0]    leaf;
  } insert_result_t;

  class insert_scoreboard;
    logic [PpnW-1:0] pool_base;
    int unsigned     first_free;
    int unsigned     alloc_count;
    logic [PteW-1:0] pte_mem [PoolPagesDef * (1 << IdxW)];
    insert_result_t  expected_inserts [$];
    int              errors;

    function new();
      pool_base   = '0;
      first_free  = 1;
      alloc_count = 0;
      errors      = 0;
      foreach (pte_mem[i]) pte_mem[i] = '0;
    endfunction

    function void set_pool(logic [PpnW-1:0] base, int unsigned ff);
      pool_base  = base;
      first_free = ff;
    endfunction

    // one upper level: follow the pointer entry or hang a fresh pool page on it
    function logic [StatusW-1:0] descend(input int unsigned page, input logic [IdxW-1:0] idx,
                                         output int unsigned child,
                                         inout logic [AllocW-1:0] taken);
      int unsigned     slot;
      int unsigned     cand;
      logic [PteW-1:0] entry;
      logic [PpnW-1:0] rel;
      slot  = page * (1 << IdxW) + idx;
      entry = pte_mem[slot];
      child = 0;
      if (entry == '0) begin
        cand = first_free + alloc_count;
        if (cand >= PoolPagesDef) return ST_EXHAUSTED;
        alloc_count++;
        taken++;
        pte_mem[slot] = {pool_base + PpnW'(cand), {(PteShift - 1){1'b0}}, 1'b1};
        child = cand;
        return ST_MAPPED;
      end
      rel = entry[PteW-1:PteShift] - pool_base;
      if (rel >= PoolPagesDef) return ST_OUTSIDE;
      child = int'(rel);
      return ST_MAPPED;
    endfunction

    function void record_insert(logic [RootW-1:0] root, logic [VpnW-1:0] vpn,
                                logic [PpnW-1:0] ppn, logic [ProtW-1:0] prot);
      insert_result_t    r;
      int unsigned       mid_pg;
      int unsigned       leaf_pg;
      logic [AllocW-1:0] taken;
      r     = '0;
      taken = '0;
      if (root >= PoolPagesDef) begin
        r.status = ST_OUTSIDE;
      end else begin
        r.status = descend(root, vpn[2*IdxW +: IdxW], mid_pg, taken);
        if (r.status == ST_MAPPED) r.status = descend(mid_pg, vpn[IdxW +: IdxW], leaf_pg, taken);
        if (r.status == ST_MAPPED) begin
          r.leaf = {ppn, {(PteShift - ProtW){1'b0}}, prot} | PteW'(1);
          pte_mem[leaf_pg * (1 << IdxW) + vpn[0 +: IdxW]] = r.leaf;
        end
      end
      r.pages = taken;
      expected_inserts.push_back(r);
    endfunction

    function void check_insert_result(logic [StatusW-1:0] status, logic [AllocW-1:0] pages,
                                      logic [PteW-1:0] leaf);
      insert_result_t want;
      if (expected_inserts.size() == 0) begin
        $error("result with no request outstanding: status %0d leaf_entry %h", status, leaf);
        errors++;
        return;
      end
      want = expected_inserts.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (pages !== want.pages) begin
        $error("pages_allocated: expected %0d, got %0d", want.pages, pages);
        errors++;
      end
      if (leaf !== want.leaf) begin
        $error("leaf_entry: expected %h, got %h", want.leaf, leaf);
        errors++;
      end
    endfunction
  endclass

  logic                 clk                 = 1'b0;
  logic                 rst_n               = 1'b0;
  logic                 in_valid            = 1'b0;
  logic                 in_ready;
  logic [RootW-1:0]     in_root_page        = '0;
  logic [VpnW-1:0]      in_virt_page        = '0;
  logic [PpnW-1:0]      in_phys_page        = '0;
  logic [ProtW-1:0]     in_prot_flags       = '0;
  logic                 out_valid;
  logic                 out_ready           = 1'b0;
  logic [StatusW-1:0]   out_status;
  logic [AllocW-1:0]    out_pages_allocated;
  logic [PteW-1:0]      out_leaf_entry;
  logic                 cfg_wr_en           = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index           = '0;
  logic [PpnW-1:0]      cfg_wdata           = '0;

  insert_scoreboard board = new();
  int burst_left  = 0;
  int gap_max     = 0;
  int stall_pct   = 0;
  int hold_left   = 0;
  int idle_cycles = 0;

  sv39_page_table_insert u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_root_page        (in_root_page),
    .in_virt_page        (in_virt_page),
    .in_phys_page        (in_phys_page),
    .in_prot_flags       (in_prot_flags),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_pages_allocated (out_pages_allocated),
    .out_leaf_entry      (out_leaf_entry),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      board.check_insert_result(out_status, out_pages_allocated, out_leaf_entry);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      hold_left = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_map(input logic [RootW-1:0] root, input logic [VpnW-1:0] vpn,
                          input logic [PpnW-1:0] ppn, input logic [ProtW-1:0] prot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_root_page  <= root;
    in_virt_page  <= vpn;
    in_phys_page  <= ppn;
    in_prot_flags <= prot;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.record_insert(root, vpn, ppn, prot);
  endtask

  // mostly walks through a few hot prefixes so lookups hit tables that exist
  task automatic send_random();
    logic [RootW-1:0] root;
    logic [VpnW-1:0]  vpn;
    if ($urandom_range(0, 9) < 7) begin
      root = RootW'($urandom_range(0, 3));
      vpn  = {HotIdx[$urandom_range(0, 3)], HotIdx[$urandom_range(0, 3)], IdxW'($urandom)};
    end else begin
      root = RootW'($urandom);
      vpn  = VpnW'($urandom);
    end
    send_map(root, vpn, PpnW'({$urandom, $urandom}), ProtW'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (board.expected_inserts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic start_phase(input logic [PpnW-1:0] base, input logic [3:0] ff,
                             input int gaps, input int stall);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_POOL_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_FIRST_FREE;
    cfg_wdata <= PpnW'(ff);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_pool(base, ff);
    gap_max   = gaps;
    stall_pct = stall;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // base at the top so pointer sums wrap
    start_phase('1, 4'd1, 4, 30);
    send_map(4'd0, 27'd0, '0, 8'h00);
    send_map(4'd0, 27'h00001ff, 44'h800_0000_0000, 8'hff);
    send_map(4'd0, 27'h7ffffff, '1, 8'h55);
    send_map(4'd0, {9'h1ff, 18'h0}, 44'h000_abcd_ef01, 8'haa);
    send_map(4'd15, 27'h2a5a5a5, 44'h555_5555_5555, 8'h0f);
    // leaf entry followed as a pointer
    send_map(4'd2, {9'h1ff, 18'h0}, 44'h000_0000_1234, 8'h01);
    send_map(4'd0, {9'h000, 9'h001, 9'h003}, 44'h3ff_0000_ffff, 8'h80);
    send_map(4'd0, 27'd0, 44'hf0f_0f0f_0f0f, 8'h7e);
    send_map(4'd1, 27'd0, 44'h0a5_a5a5_a5a5, 8'h33);
    repeat (300) send_random();

    // leave one page so the second level runs dry
    start_phase('1, 4'(15 - board.alloc_count), 0, 0);
    send_map(4'd0, {9'h123, 18'h0}, 44'h123_4567_89ab, 8'hc3);
    send_map(4'd0, {9'h124, 18'h0}, 44'h0000_0000_0001, 8'h3c);
    repeat (200) send_random();

    start_phase('0, 4'd0, 12, 60);
    repeat (400) send_random();

    start_phase(PpnW'({$urandom, $urandom}), 4'd15, 2, 10);
    repeat (200) send_random();

    start_phase('1, 4'd0, 6, 40);
    repeat (900) send_random();

    settle();
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
